FILE: design/cdu_pkg.sv
// Package for the calendar date unit: transaction payload types, command and
// status codes, and the constants used by the date arithmetic.
// No dependencies.
`default_nettype none

package cdu_pkg;

  // Command codes
  localparam logic [1:0] CmdNext = 2'd0;
  localparam logic [1:0] CmdPrev = 2'd1;
  localparam logic [1:0] CmdDiff = 2'd2;

  // Status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusRange   = 2'd1;
  localparam logic [1:0] StatusInvalid = 2'd2;

  // Calendar limits
  localparam logic [13:0] YearMax = 14'd9999;

  // floor(y / 100) = (y * Recip100) >> Recip100Shift, exact for any 14-bit y
  localparam int unsigned Recip100Shift = 19;
  localparam logic [12:0] Recip100      = 13'd5243;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [13:0] other_year;
  } cdu_in_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic [21:0] day_count;
    logic [1:0]  status;
  } cdu_out_t;

endpackage : cdu_pkg

`default_nettype wire

FILE: design/calendar_date_unit_top.sv
// Calendar date unit top level: four-stage pipeline for next day, previous
// day and day difference on Gregorian dates.
// Depends on cdu_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_i) takes one command per
//   transaction: next day, previous day, or absolute day difference between
//   the main date and the other date. Output channel (out_valid_o /
//   out_ready_i / out_o) returns exactly one result per transaction, in order.
//   A transaction passes in order through the four register stages (quotient
//   by 100, calendar checks and year base, day number, difference), one
//   transaction per cycle while the receiver does not stall.
//   Each stage holds a valid bit and loads when it is empty or its successor
//   moves, so bubbles are squeezed out and new transactions are taken while
//   a result waits at the output. When the receiver stalls, the output holds
//   and the pipeline fills; in_ready_o drops only once all four stages are
//   full. Reset empties every stage; no transaction is in flight afterward.
//   Status: ok, year range exceeded (date held), or invalid input date or
//   command (all other fields zero).
`default_nettype none

module calendar_date_unit_top (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire cdu_pkg::cdu_in_t in_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output cdu_pkg::cdu_out_t    out_o
);

  // Per-date values carried out of stage 1
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [7:0]  q100;
    logic [21:0] y365;
  } date_s1_t;

  // Per-date evaluation in stage 2
  typedef struct packed {
    logic        valid;
    logic        leap;
    logic [4:0]  mlen;
    logic [21:0] base;
  } date_eval_t;

  typedef struct packed {
    logic [1:0] cmd;
    date_s1_t   main;
    date_s1_t   other;
  } s1_t;

  // Day-number inputs for one date
  typedef struct packed {
    logic [21:0] base;
    logic        leap;
    logic [3:0]  month;
    logic [4:0]  day;
  } dn_in_t;

  typedef struct packed {
    cdu_pkg::cdu_out_t res;
    logic              is_diff;
    dn_in_t            a;
    dn_in_t            b;
  } s2_t;

  typedef struct packed {
    cdu_pkg::cdu_out_t res;
    logic              is_diff;
    logic [21:0]       dn_a;
    logic [21:0]       dn_b;
  } s3_t;

  // Days in a month, given leap flag
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                         len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
      default:                      len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before the first of month m in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Quotient by 100 through reciprocal multiply
  function automatic logic [7:0] div100(input logic [13:0] y);
    logic [26:0] prod;
    prod = 27'(y) * 27'(cdu_pkg::Recip100);
    return prod[26:cdu_pkg::Recip100Shift];
  endfunction

  // Leap flag, range check and day count before 1 January
  function automatic date_eval_t eval_date(input date_s1_t ds);
    date_eval_t  ev;
    logic [13:0] h;
    logic [6:0]  r100;
    logic        r_nz;
    logic [21:0] c4;
    logic [21:0] c100;
    logic [21:0] c400;
    h    = 14'(ds.q100) * 14'd100;
    r100 = 7'(ds.year - h);
    r_nz = (r100 != 7'd0);
    ev.leap = (ds.year[1:0] == 2'b00) && (r_nz || (ds.q100[1:0] == 2'b00));
    ev.mlen = month_len(ds.month, ev.leap);
    ev.valid = (ds.year <= cdu_pkg::YearMax) && (ds.month >= 4'd1) &&
               (ds.month <= 4'd12) && (ds.day >= 5'd1) && (ds.day <= ev.mlen);
    c4   = 22'(ds.year[13:2]) + 22'(ds.year[1:0] != 2'b00);
    c100 = 22'(ds.q100) + 22'(r_nz);
    c400 = 22'(ds.q100[7:2]) + 22'(r_nz || (ds.q100[1:0] != 2'b00));
    ev.base = ds.y365 + c4 - c100 + c400;
    return ev;
  endfunction

  // Day number from its parts
  function automatic logic [21:0] day_num(input dn_in_t x);
    logic [21:0] n;
    n = x.base + 22'(days_before(x.month)) + 22'(x.day) +
        22'(x.leap && (x.month > 4'd2));
    return n;
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  cdu_pkg::cdu_out_t out_d, out_q;

  // Per-stage load enables: a stage loads when empty or when it drains
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: quotient by 100 and 365 * year for both dates
  always_comb begin
    s1_d.cmd         = in_i.command;
    s1_d.main.day    = in_i.day;
    s1_d.main.month  = in_i.month;
    s1_d.main.year   = in_i.year;
    s1_d.main.q100   = div100(in_i.year);
    s1_d.main.y365   = 22'(in_i.year) * 22'd365;
    s1_d.other.day   = in_i.other_day;
    s1_d.other.month = in_i.other_month;
    s1_d.other.year  = in_i.other_year;
    s1_d.other.q100  = div100(in_i.other_year);
    s1_d.other.y365  = 22'(in_i.other_year) * 22'd365;
  end

  // Stage 2: validity, next/previous date and year base
  always_comb begin
    date_eval_t ea;
    date_eval_t eb;
    ea = eval_date(s1_q.main);
    eb = eval_date(s1_q.other);
    s2_d         = '0;
    s2_d.a.base  = ea.base;
    s2_d.a.leap  = ea.leap;
    s2_d.a.month = s1_q.main.month;
    s2_d.a.day   = s1_q.main.day;
    s2_d.b.base  = eb.base;
    s2_d.b.leap  = eb.leap;
    s2_d.b.month = s1_q.other.month;
    s2_d.b.day   = s1_q.other.day;
    s2_d.res.status = cdu_pkg::StatusOk;
    case (s1_q.cmd)
      cdu_pkg::CmdNext: begin
        if (!ea.valid) begin
          s2_d.res.status = cdu_pkg::StatusInvalid;
        end else if (s1_q.main.day < ea.mlen) begin
          s2_d.res.result_day   = s1_q.main.day + 5'd1;
          s2_d.res.result_month = s1_q.main.month;
          s2_d.res.result_year  = s1_q.main.year;
        end else if (s1_q.main.month < 4'd12) begin
          s2_d.res.result_day   = 5'd1;
          s2_d.res.result_month = s1_q.main.month + 4'd1;
          s2_d.res.result_year  = s1_q.main.year;
        end else if (s1_q.main.year < cdu_pkg::YearMax) begin
          s2_d.res.result_day   = 5'd1;
          s2_d.res.result_month = 4'd1;
          s2_d.res.result_year  = s1_q.main.year + 14'd1;
        end else begin
          s2_d.res.result_day   = s1_q.main.day;
          s2_d.res.result_month = s1_q.main.month;
          s2_d.res.result_year  = s1_q.main.year;
          s2_d.res.status       = cdu_pkg::StatusRange;
        end
      end
      cdu_pkg::CmdPrev: begin
        if (!ea.valid) begin
          s2_d.res.status = cdu_pkg::StatusInvalid;
        end else if (s1_q.main.day > 5'd1) begin
          s2_d.res.result_day   = s1_q.main.day - 5'd1;
          s2_d.res.result_month = s1_q.main.month;
          s2_d.res.result_year  = s1_q.main.year;
        end else if (s1_q.main.month > 4'd1) begin
          s2_d.res.result_month = s1_q.main.month - 4'd1;
          s2_d.res.result_day   = month_len(s1_q.main.month - 4'd1, ea.leap);
          s2_d.res.result_year  = s1_q.main.year;
        end else if (s1_q.main.year > 14'd0) begin
          s2_d.res.result_day   = 5'd31;
          s2_d.res.result_month = 4'd12;
          s2_d.res.result_year  = s1_q.main.year - 14'd1;
        end else begin
          s2_d.res.result_day   = s1_q.main.day;
          s2_d.res.result_month = s1_q.main.month;
          s2_d.res.result_year  = s1_q.main.year;
          s2_d.res.status       = cdu_pkg::StatusRange;
        end
      end
      cdu_pkg::CmdDiff: begin
        if (!ea.valid || !eb.valid) begin
          s2_d.res.status = cdu_pkg::StatusInvalid;
        end else begin
          s2_d.is_diff = 1'b1;
        end
      end
      default: begin
        s2_d.res.status = cdu_pkg::StatusInvalid;
      end
    endcase
  end

  // Stage 3: full day numbers
  always_comb begin
    s3_d.res     = s2_q.res;
    s3_d.is_diff = s2_q.is_diff;
    s3_d.dn_a    = day_num(s2_q.a);
    s3_d.dn_b    = day_num(s2_q.b);
  end

  // Stage 4: absolute difference into the output register
  always_comb begin
    out_d = s3_q.res;
    if (s3_q.is_diff) begin
      out_d.day_count = (s3_q.dn_a > s3_q.dn_b) ? (s3_q.dn_a - s3_q.dn_b)
                                                : (s3_q.dn_b - s3_q.dn_a);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q  <= s1_d;
    if (rdy2 && v1_q)       s2_q  <= s2_d;
    if (rdy3 && v2_q)       s3_q  <= s3_d;
    if (rdy4 && v3_q)       out_q <= out_d;
  end

  assign out_valid_o = v4_q;
  assign out_o       = out_q;

  // Input can only be blocked by a full pipeline behind a stalled output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && v1_q && v2_q && v3_q))
    else $error("input stalled without a full pipeline");

  // A non-ok status never carries a day count
  a_count_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.status != cdu_pkg::StatusOk)) |-> (out_o.day_count == 22'd0))
    else $error("day count set on error status");

  // A nonzero day count comes with a zero date
  a_diff_no_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.day_count != 22'd0)) |->
      (out_o.result_day == 5'd0 && out_o.result_month == 4'd0 &&
       out_o.result_year == 14'd0))
    else $error("difference result carries a date");

  // A stage-3 transaction reaches the output register whenever stage 4 can load
  a_stage_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4) |=> out_valid_o)
    else $error("stage 3 transaction lost");

endmodule : calendar_date_unit_top

`default_nettype wire
